FILE: design/assert_macros.svh
// assertion macros for the timer table
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

FILE: design/stt_pkg.sv
// types and constants shared by the timer table
package stt_pkg;
    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_COLLECT = 3'd1;
    localparam logic [2:0] CMD_UPDATE = 3'd2;
    localparam logic [2:0] CMD_DELETE = 3'd3;
    localparam logic [2:0] CMD_LOOKUP = 3'd4;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] key;
        logic signed [31:0] when;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        has_entry;
        logic [31:0] out_key;
        logic signed [31:0] out_when;
        logic        last;
    } t_rsp;

    typedef enum logic [3:0] {
        OP_IDLE, OP_LOAD, OP_FIND, OP_REMOVE, OP_PLACE, OP_INSERT,
        OP_COLLECT, OP_DELALL
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic done;
        logic found;
        logic full;
        logic emit;
        t_rsp rsp;
    } t_stat;
endpackage

FILE: design/stt_if.sv
// valid/ready channel interfaces
interface stt_req_if;
    logic valid;
    logic ready;
    stt_pkg::t_req payload;
    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

interface stt_rsp_if;
    logic valid;
    logic ready;
    stt_pkg::t_rsp payload;
    modport source(output valid, output payload, input ready);
    modport sink(input valid, input payload, output ready);
endinterface

FILE: design/stt_datapath.sv
// entry storage, scan pointer and shift network
module stt_datapath #(
    parameter int DEPTH = 16,
    parameter int KEY_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  stt_pkg::t_req i_req,
    input  logic          i_req_load,
    input  stt_pkg::t_cmd i_cmd,
    output stt_pkg::t_stat o_stat
);
    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [KEY_BITS-1:0] r_key [DEPTH];
    logic signed [31:0]  r_when [DEPTH];
    logic [CW-1:0] r_cnt, n_cnt;
    logic [CW-1:0] r_ptr, n_ptr;
    logic [CW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_hit_at, n_hit_at;
    logic r_hit, n_hit;
    stt_pkg::t_req r_req;
    logic [KEY_BITS-1:0] r_rkey;
    logic [KEY_BITS-1:0] cur_key;
    logic signed [31:0] cur_when, nxt_when;
    logic [IW-1:0] pidx, pidx1;
    logic in_range, key_eq;
    logic [KEY_BITS-1:0] req_key;
    logic signed [31:0] ins_when;

    assign req_key = KEY_BITS'({32'd0, i_req.key} & {64{1'b1}});
    assign in_range = r_ptr < r_cnt;
    assign pidx = r_ptr[IW-1:0];
    assign pidx1 = (r_ptr + CW'(1) < CW'(DEPTH)) ? IW'(r_ptr + CW'(1)) : pidx;
    assign cur_key = r_key[pidx];
    assign cur_when = r_when[pidx];
    assign nxt_when = r_when[pidx1];
    assign key_eq = cur_key == r_rkey;
    assign ins_when = r_req.when;

    always_comb begin
        n_cnt = r_cnt;
        n_ptr = r_ptr;
        n_pos = r_pos;
        n_hit = r_hit;
        n_hit_at = r_hit_at;
        o_stat = '0;
        o_stat.full = r_cnt == CW'(DEPTH);
        o_stat.found = r_hit;
        unique case (i_cmd.op)
            stt_pkg::OP_LOAD: begin
                n_ptr = '0;
                n_pos = '0;
                n_hit = 1'b0;
            end
            stt_pkg::OP_FIND: begin
                if (!in_range || key_eq) begin
                    o_stat.done = 1'b1;
                    n_hit = in_range;
                    n_hit_at = r_ptr;
                    o_stat.found = in_range;
                    o_stat.rsp.has_entry = in_range;
                    o_stat.rsp.out_key = 32'({{(64-KEY_BITS){1'b0}}, cur_key});
                    o_stat.rsp.out_when = cur_when;
                    n_ptr = '0;
                end else begin
                    n_ptr = r_ptr + CW'(1);
                end
            end
            stt_pkg::OP_REMOVE: begin
                if (r_ptr + CW'(1) >= r_cnt) begin
                    o_stat.done = 1'b1;
                    n_cnt = r_cnt - CW'(1);
                    n_ptr = r_cnt - CW'(1);
                end else begin
                    n_ptr = r_ptr + CW'(1);
                end
            end
            stt_pkg::OP_PLACE: begin
                if (!in_range || cur_when > ins_when
                    || (r_hit && r_ptr >= r_hit_at && cur_when == ins_when)) begin
                    o_stat.done = 1'b1;
                    // slots past the retimed entry move down once it is removed
                    n_pos = (r_hit && r_ptr > r_hit_at) ? r_ptr - CW'(1) : r_ptr;
                    n_ptr = r_hit ? r_hit_at : r_cnt;
                end else begin
                    n_ptr = r_ptr + CW'(1);
                end
            end
            stt_pkg::OP_INSERT: begin
                if (r_ptr == r_pos) begin
                    o_stat.done = 1'b1;
                    n_cnt = r_cnt + CW'(1);
                end else begin
                    n_ptr = r_ptr - CW'(1);
                end
            end
            stt_pkg::OP_COLLECT: begin
                o_stat.rsp.has_entry = 1'b1;
                o_stat.rsp.out_key = 32'({{(64-KEY_BITS){1'b0}}, cur_key});
                o_stat.rsp.out_when = cur_when;
                o_stat.rsp.last = (r_ptr + CW'(1) >= r_cnt) || nxt_when > ins_when;
                if (in_range && cur_when <= ins_when) begin
                    o_stat.emit = 1'b1;
                    o_stat.done = o_stat.rsp.last;
                    n_ptr = r_ptr + CW'(1);
                end else begin
                    o_stat.done = 1'b1;
                end
            end
            stt_pkg::OP_DELALL: begin
                if (!in_range) begin
                    o_stat.done = 1'b1;
                end else if (key_eq) begin
                    n_hit = 1'b1;
                    n_cnt = r_cnt - CW'(1);
                end else begin
                    n_ptr = r_ptr + CW'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_req_load) begin
            r_req <= i_req;
            r_rkey <= req_key;
        end
        unique case (i_cmd.op)
            stt_pkg::OP_REMOVE: begin
                if (r_ptr + CW'(1) < r_cnt) begin
                    r_key[pidx] <= r_key[pidx1];
                    r_when[pidx] <= r_when[pidx1];
                end
            end
            stt_pkg::OP_DELALL: begin
                if (in_range && key_eq) begin
                    for (int i = 0; i < DEPTH - 1; i++) begin
                        if (CW'(i) >= r_ptr) begin
                            r_key[i] <= r_key[i + 1];
                            r_when[i] <= r_when[i + 1];
                        end
                    end
                end
            end
            stt_pkg::OP_INSERT: begin
                if (r_ptr == r_pos) begin
                    r_key[pidx] <= r_rkey;
                    r_when[pidx] <= ins_when;
                end else begin
                    r_key[pidx] <= r_key[IW'(r_ptr - CW'(1))];
                    r_when[pidx] <= r_when[IW'(r_ptr - CW'(1))];
                end
            end
            default: ;
        endcase
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ptr <= '0;
            r_pos <= '0;
            r_hit <= 1'b0;
            r_hit_at <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_ptr <= n_ptr;
            r_pos <= n_pos;
            r_hit <= n_hit;
            r_hit_at <= n_hit_at;
        end
    end
endmodule

FILE: design/stt_ctrl.sv
// command sequencer for the timer table
module stt_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic [2:0]     i_in_cmd,
    output logic           o_in_ready,
    output logic           o_req_load,
    output stt_pkg::t_cmd  o_cmd,
    input  stt_pkg::t_stat i_stat,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output stt_pkg::t_rsp  o_rsp
);
    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_FIND, S_REMOVE, S_PLACE, S_INSERT, S_COLLECT,
        S_DELALL, S_OUT
    } t_state;

    t_state r_state;
    logic [2:0] r_cmd;
    logic r_any;
    logic out_busy;

    assign out_busy = o_out_valid && !i_out_ready;
    assign o_in_ready = r_state == S_IDLE && !out_busy;
    assign o_req_load = i_in_valid && o_in_ready;

    always_comb begin
        unique case (r_state)
            S_LOAD:    o_cmd.op = stt_pkg::OP_LOAD;
            S_FIND:    o_cmd.op = stt_pkg::OP_FIND;
            S_REMOVE:  o_cmd.op = stt_pkg::OP_REMOVE;
            S_PLACE:   o_cmd.op = stt_pkg::OP_PLACE;
            S_INSERT:  o_cmd.op = stt_pkg::OP_INSERT;
            S_COLLECT: o_cmd.op = out_busy ? stt_pkg::OP_IDLE : stt_pkg::OP_COLLECT;
            S_DELALL:  o_cmd.op = stt_pkg::OP_DELALL;
            default:   o_cmd.op = stt_pkg::OP_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            o_out_valid <= 1'b0;
            r_cmd <= '0;
            r_any <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) o_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (o_req_load) begin
                    r_cmd <= i_in_cmd;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_any <= 1'b0;
                    priority case (r_cmd)
                        stt_pkg::CMD_ADD:     r_state <= S_PLACE;
                        stt_pkg::CMD_COLLECT: r_state <= S_COLLECT;
                        stt_pkg::CMD_UPDATE:  r_state <= S_FIND;
                        stt_pkg::CMD_DELETE:  r_state <= S_DELALL;
                        stt_pkg::CMD_LOOKUP:  r_state <= S_FIND;
                        default: begin
                            o_rsp <= '0;
                            o_rsp.last <= 1'b1;
                            r_state <= S_OUT;
                        end
                    endcase
                    if (r_cmd == stt_pkg::CMD_ADD && i_stat.full) begin
                        o_rsp <= '0;
                        o_rsp.status <= stt_pkg::ST_FULL;
                        o_rsp.last <= 1'b1;
                        r_state <= S_OUT;
                    end
                end
                S_FIND: if (i_stat.done) begin
                    o_rsp <= '0;
                    o_rsp.last <= 1'b1;
                    if (!i_stat.found) begin
                        o_rsp.status <= stt_pkg::ST_NOT_FOUND;
                        r_state <= S_OUT;
                    end else if (r_cmd == stt_pkg::CMD_LOOKUP) begin
                        o_rsp <= i_stat.rsp;
                        o_rsp.status <= stt_pkg::ST_OK;
                        o_rsp.last <= 1'b1;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_PLACE;
                    end
                end
                S_PLACE: if (i_stat.done) begin
                    r_state <= S_REMOVE;
                    if (r_cmd == stt_pkg::CMD_ADD) begin
                        r_state <= S_INSERT;
                    end
                end
                S_REMOVE: if (i_stat.done) r_state <= S_INSERT;
                S_INSERT: if (i_stat.done) begin
                    o_rsp <= '0;
                    o_rsp.last <= 1'b1;
                    r_state <= S_OUT;
                end
                S_DELALL: if (i_stat.done) begin
                    o_rsp <= '0;
                    o_rsp.last <= 1'b1;
                    o_rsp.status <= i_stat.found ? stt_pkg::ST_OK : stt_pkg::ST_NOT_FOUND;
                    r_state <= S_OUT;
                end
                S_COLLECT: if (!out_busy) begin
                    if (i_stat.emit) begin
                        o_rsp <= i_stat.rsp;
                        o_out_valid <= 1'b1;
                        r_any <= 1'b1;
                        if (i_stat.done) r_state <= S_IDLE;
                    end else begin
                        o_rsp <= '0;
                        o_rsp.last <= 1'b1;
                        r_state <= r_any ? S_IDLE : S_OUT;
                    end
                end
                S_OUT: if (!out_busy) begin
                    o_out_valid <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: design/sorted_timer_table.sv
// sorted timer table top level
// channel   dir  payload
// i_req     in   cmd, key, when
// o_rsp     out  status, has_entry, out_key, out_when, last
// an item is worked through by one-slot-per-cycle scan, shift and insert
// passes over the entry store
// collect emits one result per cycle when the sink is ready
// a stalled result holds the sequencer; reset is synchronous and empties the table
`include "assert_macros.svh"
module sorted_timer_table #(
    parameter int DEPTH = 16,
    parameter int KEY_BITS = 32
) (
    input logic i_clk,
    input logic i_rst_n,
    stt_req_if.sink   i_req,
    stt_rsp_if.source o_rsp
);
    stt_pkg::t_cmd  cmd;
    stt_pkg::t_stat stat;
    logic req_load;

    stt_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_req.valid), .i_in_cmd(i_req.payload.cmd),
        .o_in_ready(i_req.ready), .o_req_load(req_load),
        .o_cmd(cmd), .i_stat(stat),
        .o_out_valid(o_rsp.valid), .i_out_ready(o_rsp.ready),
        .o_rsp(o_rsp.payload)
    );

    stt_datapath #(.DEPTH(DEPTH), .KEY_BITS(KEY_BITS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req(i_req.payload), .i_req_load(req_load),
        .i_cmd(cmd), .o_stat(stat)
    );

    `CHK_IMPL(a_no_accept_busy, i_clk, i_rst_n, o_rsp.valid && !o_rsp.ready, !i_req.ready)
    `CHK_IMPL(a_empty_no_entry, i_clk, i_rst_n, o_rsp.valid && o_rsp.payload.status != stt_pkg::ST_OK, !o_rsp.payload.has_entry)
    `CHK_NEXT(a_accept_busy, i_clk, i_rst_n, i_req.valid && i_req.ready, !i_req.ready)
endmodule
